### rtl/core/pgm_gray_histogram_macros.svh
// ----------------------------------------------------------------------------
// pgm_gray_histogram assertion macros
// shared assertion forms for the gray histogram block
// ----------------------------------------------------------------------------
`ifndef PGM_GRAY_HISTOGRAM_MACROS_SVH
`define PGM_GRAY_HISTOGRAM_MACROS_SVH

// same-cycle implication
`define PGH_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define PGH_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/core/pgh_pkg.sv
// ----------------------------------------------------------------------------
// pgh_pkg
// types, codes and helpers shared by the gray histogram block
// ----------------------------------------------------------------------------
package pgh_pkg;

   localparam int BIN_COUNT_BITS = 32;
   localparam int DIM_BITS       = 16;
   localparam int NUM_BINS       = 256;
   localparam int BIN_IDX_BITS   = 8;
   localparam int RSP_COUNT_BITS = 32;
   localparam int PIXEL_BITS     = 2 * DIM_BITS;
   localparam int QUEUE_DEPTH    = 3;
   localparam int REQ_TDATA_BITS = 16;
   localparam int RSP_TDATA_BITS = 72;

   localparam logic [1:0] ACT_START = 2'd0;
   localparam logic [1:0] ACT_BYTE  = 2'd1;
   localparam logic [1:0] ACT_READ  = 2'd2;

   localparam logic [7:0] MAGIC_P    = 8'h50;
   localparam logic [7:0] MAGIC_5    = 8'h35;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;

   localparam logic [1:0] POS_FIRST  = 2'd0;
   localparam logic [1:0] POS_SECOND = 2'd1;
   localparam logic [1:0] POS_SEP    = 2'd2;

   localparam logic [DIM_BITS-1:0]       DIM_MAX = {DIM_BITS{1'b1}};
   localparam logic [BIN_COUNT_BITS-1:0] BIN_MAX = {BIN_COUNT_BITS{1'b1}};

   typedef enum logic [2:0] {
      PH_MAGIC  = 3'd0,
      PH_WIDTH  = 3'd1,
      PH_HEIGHT = 3'd2,
      PH_MAXVAL = 3'd3,
      PH_PIXELS = 3'd4,
      PH_BAD    = 3'd5
   } pgh_phase_type;

   typedef struct packed {
      logic                    valid;
      logic                    clear;
      logic                    pixel;
      logic                    read;
      logic [BIN_IDX_BITS-1:0] idx;
   } pgh_op_type;

   typedef struct packed {
      logic                complete;
      pgh_phase_type       phase;
      logic [DIM_BITS-1:0] height;
      logic [DIM_BITS-1:0] width;
   } pgh_status_type;

   typedef struct packed {
      pgh_status_type            status;
      logic [RSP_COUNT_BITS-1:0] count;
   } pgh_rsp_type;

   function automatic logic is_digit(input logic [7:0] b);
      return (b >= CHAR_ZERO) && (b <= CHAR_NINE);
   endfunction

   function automatic logic [DIM_BITS-1:0] dim_digit(input logic [DIM_BITS-1:0] acc,
                                                     input logic [7:0] b);
      logic [7:0]          d;
      logic [DIM_BITS+3:0] sum;
      d   = b - CHAR_ZERO;
      sum = (DIM_BITS+4)'({acc, 3'b000}) + (DIM_BITS+4)'({acc, 1'b0})
          + (DIM_BITS+4)'(d[3:0]);
      return (sum > (DIM_BITS+4)'(DIM_MAX)) ? DIM_MAX : sum[DIM_BITS-1:0];
   endfunction

endpackage

### rtl/core/pgh_parser.sv
// ----------------------------------------------------------------------------
// pgh_parser
// header parser and pixel counter; issues bin operations per request
// ----------------------------------------------------------------------------
module pgh_parser (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_accept,
   input  logic [1:0]             action,
   input  logic [7:0]             file_byte,
   input  logic [7:0]             bin_index,
   output pgh_pkg::pgh_op_type     op,
   output pgh_pkg::pgh_status_type status
);
   import pgh_pkg::*;

   pgh_phase_type           phase_ff, phase_in;
   logic [1:0]              pos_ff, pos_in;
   logic [DIM_BITS-1:0]     width_ff, width_in;
   logic [DIM_BITS-1:0]     height_ff, height_in;
   logic [PIXEL_BITS-1:0]   pixels_ff, pixels_in;
   logic                    complete_ff, complete_in;
   logic [PIXEL_BITS-1:0]   product_ff;
   logic                    is_start;
   logic                    is_byte;

   assign is_start = req_accept && (action == ACT_START);
   assign is_byte  = req_accept && (action == ACT_BYTE);

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (is_start) begin
         phase_in = PH_MAGIC;
      end else if (is_byte) begin
         unique case (phase_ff)
            PH_MAGIC: begin
               if (pos_ff == POS_FIRST) begin
                  if (file_byte != MAGIC_P) phase_in = PH_BAD;
               end else if (pos_ff == POS_SECOND) begin
                  if (file_byte != MAGIC_5) phase_in = PH_BAD;
               end else begin
                  phase_in = PH_WIDTH;
               end
            end
            PH_WIDTH: begin
               if (file_byte == CHAR_SPACE) phase_in = PH_HEIGHT;
            end
            PH_HEIGHT: begin
               if (file_byte == CHAR_LF) phase_in = PH_MAXVAL;
            end
            PH_MAXVAL: begin
               if (file_byte == CHAR_LF) phase_in = PH_PIXELS;
            end
            PH_PIXELS: phase_in = PH_PIXELS;
            PH_BAD:    phase_in = PH_BAD;
            default:   phase_in = phase_ff;
         endcase
      end
   end

   // datapath and bin operation
   always_comb begin
      pos_in      = pos_ff;
      width_in    = width_ff;
      height_in   = height_ff;
      pixels_in   = pixels_ff;
      complete_in = complete_ff;
      op          = '0;
      op.valid    = req_accept;
      op.idx      = bin_index;
      if (req_accept) begin
         unique case (action)
            ACT_START: begin
               pos_in      = POS_FIRST;
               width_in    = '0;
               height_in   = '0;
               pixels_in   = '0;
               complete_in = 1'b0;
               op.clear    = 1'b1;
            end
            ACT_READ: begin
               op.read = 1'b1;
            end
            ACT_BYTE: begin
               unique case (phase_ff)
                  PH_MAGIC: begin
                     if (pos_ff == POS_FIRST) begin
                        if (file_byte == MAGIC_P) pos_in = POS_SECOND;
                     end else if (pos_ff == POS_SECOND) begin
                        if (file_byte == MAGIC_5) pos_in = POS_SEP;
                     end else begin
                        pos_in = POS_FIRST;
                     end
                  end
                  PH_WIDTH: begin
                     if (file_byte != CHAR_SPACE && is_digit(file_byte))
                        width_in = dim_digit(width_ff, file_byte);
                  end
                  PH_HEIGHT: begin
                     if (file_byte != CHAR_LF && is_digit(file_byte))
                        height_in = dim_digit(height_ff, file_byte);
                  end
                  PH_MAXVAL: begin
                     if (file_byte == CHAR_LF)
                        complete_in = (width_ff == '0) || (height_ff == '0);
                  end
                  PH_PIXELS: begin
                     if (!complete_ff) begin
                        op.pixel    = 1'b1;
                        op.idx      = file_byte;
                        pixels_in   = pixels_ff + PIXEL_BITS'(1);
                        complete_in = (pixels_in == product_ff);
                     end
                  end
                  PH_BAD: begin
                     pos_in = pos_ff;
                  end
                  default: begin
                     pos_in = pos_ff;
                  end
               endcase
            end
            default: begin
               op.valid = req_accept;
            end
         endcase
      end
   end

   assign status.complete = complete_in;
   assign status.phase    = phase_in;
   assign status.height   = height_in;
   assign status.width    = width_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_MAGIC;
         pos_ff      <= POS_FIRST;
         width_ff    <= '0;
         height_ff   <= '0;
         pixels_ff   <= '0;
         complete_ff <= 1'b0;
      end else begin
         phase_ff    <= phase_in;
         pos_ff      <= pos_in;
         width_ff    <= width_in;
         height_ff   <= height_in;
         pixels_ff   <= pixels_in;
         complete_ff <= complete_in;
      end
   end

   // pixel total, settled before the first pixel arrives
   always_ff @(posedge clock) begin
      product_ff <= PIXEL_BITS'(width_ff) * PIXEL_BITS'(height_ff);
   end

endmodule

### rtl/core/pgh_bins.sv
// ----------------------------------------------------------------------------
// pgh_bins
// bin memory with valid bits; read-modify-write with write forwarding
// ----------------------------------------------------------------------------
module pgh_bins (
   input  logic                   clock,
   input  logic                   reset,
   input  pgh_pkg::pgh_op_type     op,
   input  pgh_pkg::pgh_status_type status,
   output logic                   res_valid,
   output pgh_pkg::pgh_rsp_type    res
);
   import pgh_pkg::*;

   logic [BIN_COUNT_BITS-1:0] mem [NUM_BINS];
   logic [NUM_BINS-1:0]       bin_valid_ff, bin_valid_in;

   logic                      s1_valid_ff;
   logic                      s1_pixel_ff;
   logic                      s1_read_ff;
   logic [BIN_IDX_BITS-1:0]   s1_idx_ff;
   logic                      s1_old_valid_ff;
   pgh_status_type            s1_status_ff;
   logic [BIN_COUNT_BITS-1:0] rd_data_ff;
   logic                      fwd_ff;
   logic [BIN_COUNT_BITS-1:0] fwd_data_ff;

   logic [BIN_COUNT_BITS-1:0] cur_count;
   logic [BIN_COUNT_BITS-1:0] new_count;
   logic                      wr_en;

   always_comb begin
      bin_valid_in = bin_valid_ff;
      if (op.valid && op.clear) begin
         bin_valid_in = '0;
      end else if (op.valid && op.pixel) begin
         bin_valid_in[op.idx] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bin_valid_ff <= '0;
         s1_valid_ff  <= 1'b0;
      end else begin
         bin_valid_ff <= bin_valid_in;
         s1_valid_ff  <= op.valid;
      end
   end

   assign cur_count = fwd_ff ? fwd_data_ff : rd_data_ff;
   assign new_count = !s1_old_valid_ff ? BIN_COUNT_BITS'(1)
                    : (cur_count == BIN_MAX) ? cur_count
                    : cur_count + BIN_COUNT_BITS'(1);
   assign wr_en     = s1_valid_ff && s1_pixel_ff;

   always_ff @(posedge clock) begin
      rd_data_ff      <= mem[op.idx];
      fwd_ff          <= wr_en && (s1_idx_ff == op.idx);
      fwd_data_ff     <= new_count;
      s1_pixel_ff     <= op.pixel;
      s1_read_ff      <= op.read;
      s1_idx_ff       <= op.idx;
      s1_old_valid_ff <= bin_valid_ff[op.idx];
      s1_status_ff    <= status;
      if (wr_en) begin
         mem[s1_idx_ff] <= new_count;
      end
   end

   assign res_valid  = s1_valid_ff;
   assign res.status = s1_status_ff;
   assign res.count  = (s1_read_ff && s1_old_valid_ff) ? cur_count[RSP_COUNT_BITS-1:0] : '0;

endmodule

### rtl/core/pgh_outq.sv
// ----------------------------------------------------------------------------
// pgh_outq
// small response queue decoupling the pipeline from the receiver
// ----------------------------------------------------------------------------
module pgh_outq (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  pgh_pkg::pgh_rsp_type push_data,
   input  logic                pop,
   output logic                not_empty,
   output pgh_pkg::pgh_rsp_type head_data,
   output logic [1:0]          level
);
   import pgh_pkg::*;

   pgh_rsp_type entry_ff [QUEUE_DEPTH];
   logic [1:0]  head_ff, head_in;
   logic [1:0]  tail_ff, tail_in;
   logic [1:0]  level_ff, level_in;

   function automatic logic [1:0] ptr_next(input logic [1:0] p);
      return (p == 2'(QUEUE_DEPTH - 1)) ? 2'd0 : p + 2'd1;
   endfunction

   always_comb begin
      head_in  = pop  ? ptr_next(head_ff) : head_ff;
      tail_in  = push ? ptr_next(tail_ff) : tail_ff;
      level_in = level_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         level_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         level_ff <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[tail_ff] <= push_data;
      end
   end

   assign not_empty = (level_ff != '0);
   assign head_data = entry_ff[head_ff];
   assign level     = level_ff;

endmodule

### rtl/core/pgm_gray_histogram.sv
// ----------------------------------------------------------------------------
// pgm_gray_histogram
// gray-level histogram of a binary pgm image streamed one byte per request
// ----------------------------------------------------------------------------
// req_ carries one request: start (clears parser and bins), one file byte,
// or a read of one bin. every request yields exactly one response on rsp_
// holding the bin count (zero unless a read), the parsed width and height,
// the parse phase and the image-complete flag as they stand after it.
// each response passes through the bin stage register and then the response queue.
// throughput: one request per cycle while req_tready is high; each pixel is a
// registered read and a write back into the bin memory, with forwarding when the
// same gray level follows directly.
// a 3-entry response queue takes results; req_tready drops only when it
// and the bin stage hold 3 responses, so a stalled receiver stops intake
// after at most 3 requests and loses nothing.
// reset clears the parser, all bin valid bits and the queue; req_tready
// stays low while reset is held.
// bins whose valid bit is clear read as zero.
// ----------------------------------------------------------------------------
`include "pgm_gray_histogram_macros.svh"

module pgm_gray_histogram (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // [7:0] file_byte, [15:8] bin_index
   input  logic [pgh_pkg::REQ_TDATA_BITS-1:0] req_tdata,
   // [1:0] action
   input  logic [1:0]                         req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [31:0] bin_count, [47:32] image_width, [63:48] image_height,
   // [66:64] phase, [67] image_complete, [71:68] zero
   output logic [pgh_pkg::RSP_TDATA_BITS-1:0] rsp_tdata
);
   import pgh_pkg::*;

   logic           req_accept;
   logic           rsp_pop;
   pgh_op_type     op;
   pgh_status_type status;
   logic           res_valid;
   pgh_rsp_type    res;
   pgh_rsp_type    head_data;
   logic [1:0]     q_level;
   logic [2:0]     occupancy;

   assign occupancy  = {1'b0, q_level} + {2'b00, res_valid};
   assign req_tready = !reset && (occupancy < 3'(QUEUE_DEPTH));
   assign req_accept = req_tvalid && req_tready;
   assign rsp_pop    = rsp_tvalid && rsp_tready;

   pgh_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .req_accept (req_accept),
      .action     (req_tuser),
      .file_byte  (req_tdata[7:0]),
      .bin_index  (req_tdata[15:8]),
      .op         (op),
      .status     (status)
   );

   pgh_bins u_bins (
      .clock     (clock),
      .reset     (reset),
      .op        (op),
      .status    (status),
      .res_valid (res_valid),
      .res       (res)
   );

   pgh_outq u_outq (
      .clock     (clock),
      .reset     (reset),
      .push      (res_valid),
      .push_data (res),
      .pop       (rsp_pop),
      .not_empty (rsp_tvalid),
      .head_data (head_data),
      .level     (q_level)
   );

   assign rsp_tdata = {(RSP_TDATA_BITS - $bits(pgh_rsp_type))'(0), head_data};

   `PGH_ASSERT_IMP(a_queue_room, clock, reset, res_valid && !rsp_pop, q_level != 2'(QUEUE_DEPTH), "response queue overflow")
   `PGH_ASSERT_NXT(a_one_rsp_per_req, clock, reset, req_accept, res_valid, "accepted request produced no result")
   `PGH_ASSERT_IMP(a_complete_phase, clock, reset, rsp_tvalid && rsp_tdata[67], rsp_tdata[66:64] == PH_PIXELS, "image complete outside pixel phase")

endmodule

### bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the pgm gray-level histogram block
// ----------------------------------------------------------------------------
// a short table of directed requests (magic errors, header parsing, pixel
// counting, reads, the unused action) is followed by random p5 images with
// random dimensions, header noise and pixel data, mixed with broken streams.
// every accepted request is run through a local histogram predictor and the
// response is compared field by field. both sides idle at random, and the
// receiver holds off once for a long stretch so that the block stalls.
// ----------------------------------------------------------------------------
module testbench;
   import pgh_pkg::*;

   localparam logic [1:0] ACT_NONE = 2'd3;

   typedef struct packed {
      logic [1:0]    act;
      logic [7:0]    fbyte;
      logic [7:0]    idx;
      logic          typed;
      logic [31:0]   count;
      logic [15:0]   width;
      logic [15:0]   height;
      pgh_phase_type phase;
      logic          complete;
   } stim_row_type;

   logic                      clock      = 1'b0;
   logic                      reset      = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [REQ_TDATA_BITS-1:0] req_tdata  = '0;
   logic [1:0]                req_tuser  = '0;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [RSP_TDATA_BITS-1:0] rsp_tdata;

   logic        calm     = 1'b0;
   logic        hold_rsp = 1'b0;
   int unsigned requests_accepted = 0;
   int unsigned random_items      = 0;
   int unsigned mismatches        = 0;
   pgh_rsp_type rsp_expected [$];

   // predictor state
   pgh_phase_type     ph_state    = PH_MAGIC;
   logic [1:0]        magic_pos   = POS_FIRST;
   logic [15:0]       width_sum   = '0;
   logic [15:0]       height_sum  = '0;
   logic [31:0]       pixel_total = '0;
   logic [31:0]       gray_bins [NUM_BINS];
   bit                gray_live [NUM_BINS];

   stim_row_type directed_rows [25] = '{
      '{ACT_READ,  8'h00, 8'h00, 1'b1, 32'd0, 16'd0, 16'd0, PH_MAGIC,  1'b0},
      '{ACT_BYTE,  8'h51, 8'h00, 1'b1, 32'd0, 16'd0, 16'd0, PH_BAD,    1'b0},
      '{ACT_BYTE,  8'h50, 8'h00, 1'b1, 32'd0, 16'd0, 16'd0, PH_BAD,    1'b0},
      '{ACT_START, 8'h00, 8'h00, 1'b1, 32'd0, 16'd0, 16'd0, PH_MAGIC,  1'b0},
      '{ACT_BYTE,  8'h50, 8'h00, 1'b0, 32'd0, 16'd0, 16'd0, PH_MAGIC,  1'b0},
      '{ACT_BYTE,  8'h34, 8'h00, 1'b1, 32'd0, 16'd0, 16'd0, PH_BAD,    1'b0},
      '{ACT_START, 8'h00, 8'h00, 1'b1, 32'd0, 16'd0, 16'd0, PH_MAGIC,  1'b0},
      '{ACT_BYTE,  8'h50, 8'h00, 1'b0, 32'd0, 16'd0, 16'd0, PH_MAGIC,  1'b0},
      '{ACT_BYTE,  8'h35, 8'h00, 1'b0, 32'd0, 16'd0, 16'd0, PH_MAGIC,  1'b0},
      '{ACT_BYTE,  8'hFF, 8'h00, 1'b0, 32'd0, 16'd0, 16'd0, PH_MAGIC,  1'b0},
      '{ACT_BYTE,  8'h32, 8'h00, 1'b0, 32'd0, 16'd0, 16'd0, PH_MAGIC,  1'b0},
      '{ACT_BYTE,  8'h41, 8'h00, 1'b0, 32'd0, 16'd0, 16'd0, PH_MAGIC,  1'b0},
      '{ACT_BYTE,  8'h20, 8'h00, 1'b0, 32'd0, 16'd0, 16'd0, PH_MAGIC,  1'b0},
      '{ACT_BYTE,  8'h31, 8'h00, 1'b0, 32'd0, 16'd0, 16'd0, PH_MAGIC,  1'b0},
      '{ACT_BYTE,  8'h0A, 8'h00, 1'b0, 32'd0, 16'd0, 16'd0, PH_MAGIC,  1'b0},
      '{ACT_BYTE,  8'h39, 8'h00, 1'b0, 32'd0, 16'd0, 16'd0, PH_MAGIC,  1'b0},
      '{ACT_BYTE,  8'h0A, 8'h00, 1'b0, 32'd0, 16'd0, 16'd0, PH_MAGIC,  1'b0},
      '{ACT_BYTE,  8'hFF, 8'hFF, 1'b0, 32'd0, 16'd0, 16'd0, PH_MAGIC,  1'b0},
      '{ACT_BYTE,  8'hFF, 8'h00, 1'b0, 32'd0, 16'd0, 16'd0, PH_MAGIC,  1'b0},
      '{ACT_BYTE,  8'h00, 8'h00, 1'b0, 32'd0, 16'd0, 16'd0, PH_MAGIC,  1'b0},
      '{ACT_READ,  8'h00, 8'hFF, 1'b1, 32'd2, 16'd2, 16'd1, PH_PIXELS, 1'b1},
      '{ACT_READ,  8'hFF, 8'h00, 1'b0, 32'd0, 16'd0, 16'd0, PH_MAGIC,  1'b0},
      '{ACT_NONE,  8'hFF, 8'hFF, 1'b0, 32'd0, 16'd0, 16'd0, PH_MAGIC,  1'b0},
      '{ACT_START, 8'hFF, 8'hFF, 1'b1, 32'd0, 16'd0, 16'd0, PH_MAGIC,  1'b0},
      '{ACT_READ,  8'h00, 8'hFF, 1'b1, 32'd0, 16'd0, 16'd0, PH_MAGIC,  1'b0}
   };

   pgm_gray_histogram i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic logic [15:0] decimal_push(input logic [15:0] acc, input logic [7:0] b);
      logic [20:0] next;
      next = 21'(acc) * 21'd10 + 21'(b - CHAR_ZERO);
      return (next > 21'(DIM_MAX)) ? DIM_MAX : next[15:0];
   endfunction

   function automatic pgh_rsp_type histogram_step(input logic [1:0] act, input logic [7:0] b,
                                                  input logic [7:0] idx);
      pgh_rsp_type r;
      logic [31:0] area;
      r    = '0;
      area = {16'd0, width_sum} * {16'd0, height_sum};
      case (act)
         ACT_START: begin
            ph_state    = PH_MAGIC;
            magic_pos   = POS_FIRST;
            width_sum   = '0;
            height_sum  = '0;
            pixel_total = '0;
            foreach (gray_live[i]) gray_live[i] = 1'b0;
         end
         ACT_BYTE: begin
            case (ph_state)
               PH_MAGIC: begin
                  if (magic_pos == POS_FIRST) begin
                     if (b != MAGIC_P) ph_state = PH_BAD;
                     else magic_pos = POS_SECOND;
                  end else if (magic_pos == POS_SECOND) begin
                     if (b != MAGIC_5) ph_state = PH_BAD;
                     else magic_pos = POS_SEP;
                  end else begin
                     magic_pos = POS_FIRST;
                     ph_state  = PH_WIDTH;
                  end
               end
               PH_WIDTH: begin
                  if (b == CHAR_SPACE) ph_state = PH_HEIGHT;
                  else if (b >= CHAR_ZERO && b <= CHAR_NINE)
                     width_sum = decimal_push(width_sum, b);
               end
               PH_HEIGHT: begin
                  if (b == CHAR_LF) ph_state = PH_MAXVAL;
                  else if (b >= CHAR_ZERO && b <= CHAR_NINE)
                     height_sum = decimal_push(height_sum, b);
               end
               PH_MAXVAL: begin
                  if (b == CHAR_LF) ph_state = PH_PIXELS;
               end
               PH_PIXELS: begin
                  if (pixel_total < area) begin
                     if (!gray_live[b]) begin
                        gray_bins[b] = 32'd1;
                        gray_live[b] = 1'b1;
                     end else if (gray_bins[b] != BIN_MAX) begin
                        gray_bins[b] = gray_bins[b] + 32'd1;
                     end
                     pixel_total = pixel_total + 32'd1;
                  end
               end
               default: ;
            endcase
         end
         ACT_READ: r.count = gray_live[idx] ? gray_bins[idx] : 32'd0;
         default: ;
      endcase
      area              = {16'd0, width_sum} * {16'd0, height_sum};
      r.status.width    = width_sum;
      r.status.height   = height_sum;
      r.status.phase    = ph_state;
      r.status.complete = (ph_state == PH_PIXELS) && (pixel_total >= area);
      return r;
   endfunction

   task automatic send_request(input logic [1:0] act, input logic [7:0] fbyte,
                               input logic [7:0] idx, input logic typed,
                               input pgh_rsp_type typed_rsp);
      pgh_rsp_type predicted;
      bit          placed;
      placed = 1'b0;
      while (!placed) begin
         @(negedge clock);
         if (!calm && $urandom_range(99) < 23) begin
            req_tvalid <= 1'b0;
            req_tdata  <= REQ_TDATA_BITS'($urandom);
            req_tuser  <= 2'($urandom);
         end else begin
            req_tvalid <= 1'b1;
            req_tdata  <= {idx, fbyte};
            req_tuser  <= act;
            placed = 1'b1;
         end
      end
      do @(posedge clock); while (!req_tready);
      predicted = histogram_step(act, fbyte, idx);
      rsp_expected.push_back(typed ? typed_rsp : predicted);
      requests_accepted++;
   endtask

   task automatic emit(input logic [1:0] act, input logic [7:0] fbyte, input logic [7:0] idx);
      send_request(act, fbyte, idx, 1'b0, '0);
      random_items++;
   endtask

   task automatic emit_byte(input logic [7:0] b);
      emit(ACT_BYTE, b, 8'($urandom));
   endtask

   // decimal digits with the odd leading zero and ignored non-digit bytes
   task automatic emit_number(input int unsigned value, input logic [7:0] stop);
      string      digits;
      logic [7:0] junk;
      digits = $sformatf("%0d", value);
      if ($urandom_range(7) == 0) emit_byte(CHAR_ZERO);
      for (int k = 0; k < digits.len(); k++) begin
         if ($urandom_range(9) == 0) begin
            do junk = 8'($urandom);
            while ((junk >= CHAR_ZERO && junk <= CHAR_NINE) || junk == stop);
            emit_byte(junk);
         end
         emit_byte(8'(digits[k]));
      end
   endtask

   task automatic stream_image();
      int unsigned w, h;
      longint      npix;
      logic [7:0]  px;
      logic [7:0]  b;
      emit(ACT_START, 8'($urandom), 8'($urandom));
      w = ($urandom_range(9) == 0) ? $urandom_range(9999999, 60000) : $urandom_range(8, 0);
      h = ($urandom_range(9) == 0) ? $urandom_range(9999999, 60000) : $urandom_range(5, 0);
      emit_byte(MAGIC_P);
      emit_byte(MAGIC_5);
      emit_byte(8'($urandom));
      emit_number(w, CHAR_SPACE);
      emit_byte(CHAR_SPACE);
      emit_number(h, CHAR_LF);
      emit_byte(CHAR_LF);
      repeat ($urandom_range(4, 0)) begin
         do b = 8'($urandom); while (b == CHAR_LF);
         emit_byte(b);
      end
      emit_byte(CHAR_LF);
      npix = longint'(w) * longint'(h);
      if (npix > 40) npix = 40;
      npix = npix + $urandom_range(3, 0);
      px   = 8'($urandom);
      for (longint i = 0; i < npix; i++) begin
         if ($urandom_range(9) == 0) emit(ACT_READ, 8'($urandom), 8'($urandom));
         if ($urandom_range(29) == 0) emit(ACT_NONE, 8'($urandom), 8'($urandom));
         if ($urandom_range(2) != 0) px = ($urandom_range(1) == 0) ? 8'($urandom)
                                                                    : 8'($urandom_range(7, 0));
         emit_byte(px);
      end
      repeat ($urandom_range(6, 2)) begin
         emit(ACT_READ, 8'($urandom), ($urandom_range(1) == 0) ? px : 8'($urandom));
      end
   endtask

   task automatic stream_noise();
      if ($urandom_range(1) == 0) begin
         emit(ACT_START, 8'($urandom), 8'($urandom));
         emit_byte(($urandom_range(1) == 0) ? MAGIC_P : 8'($urandom));
         emit_byte(($urandom_range(1) == 0) ? MAGIC_5 : 8'($urandom));
      end
      repeat ($urandom_range(8, 1)) emit(2'($urandom), 8'($urandom), 8'($urandom));
   endtask

   always @(negedge clock) begin
      rsp_tready <= !hold_rsp && (calm || $urandom_range(99) >= 23);
   end

   // long receiver stall so the response queue fills and intake stops
   initial begin
      wait (requests_accepted >= 300);
      @(posedge clock);
      hold_rsp = 1'b1;
      repeat (150) @(posedge clock);
      hold_rsp = 1'b0;
   end

   always @(posedge clock) begin : rsp_check
      pgh_rsp_type got;
      pgh_rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[$bits(pgh_rsp_type)-1:0];
         if (rsp_tdata[RSP_TDATA_BITS-1:$bits(pgh_rsp_type)] !== '0) begin
            $error("pad expected 0 got %h", rsp_tdata[RSP_TDATA_BITS-1:$bits(pgh_rsp_type)]);
            mismatches++;
         end
         if (rsp_expected.size() == 0) begin
            $error("response with no request outstanding");
            mismatches++;
         end else begin
            want = rsp_expected.pop_front();
            if (got.count !== want.count) begin
               $error("bin_count expected %0d got %0d", want.count, got.count);
               mismatches++;
            end
            if (got.status.width !== want.status.width) begin
               $error("image_width expected %0d got %0d", want.status.width, got.status.width);
               mismatches++;
            end
            if (got.status.height !== want.status.height) begin
               $error("image_height expected %0d got %0d", want.status.height,
                      got.status.height);
               mismatches++;
            end
            if (got.status.phase !== want.status.phase) begin
               $error("phase expected %0d got %0d", want.status.phase, got.status.phase);
               mismatches++;
            end
            if (got.status.complete !== want.status.complete) begin
               $error("image_complete expected %0d got %0d", want.status.complete,
                      got.status.complete);
               mismatches++;
            end
         end
      end
   end

   initial begin
      pgh_rsp_type typed_rsp;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      foreach (directed_rows[k]) begin
         typed_rsp.count           = directed_rows[k].count;
         typed_rsp.status.width    = directed_rows[k].width;
         typed_rsp.status.height   = directed_rows[k].height;
         typed_rsp.status.phase    = directed_rows[k].phase;
         typed_rsp.status.complete = directed_rows[k].complete;
         send_request(directed_rows[k].act, directed_rows[k].fbyte, directed_rows[k].idx,
                      directed_rows[k].typed, typed_rsp);
      end
      while (random_items < 1500) begin
         calm = (random_items >= 600) && (random_items < 850);
         if ($urandom_range(99) < 85) stream_image();
         else stream_noise();
      end
      calm = 1'b0;
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (rsp_expected.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (mismatches == 0) $display("testbench OK");
      else $display("testbench NOT OK");
      $finish;
   end

   initial begin
      #5ms;
      $display("testbench NOT OK");
      $finish;
   end

endmodule

### sim.f
+incdir+rtl/core
rtl/core/pgh_pkg.sv
rtl/core/pgh_parser.sv
rtl/core/pgh_bins.sv
rtl/core/pgh_outq.sv
rtl/core/pgm_gray_histogram.sv
bench/testbench.sv
